// File: rtl/xml_entity_decode_stream_top_macros.svh
// Assertion macros used by the checker file of the entity decoder.
`ifndef XML_ENTITY_DECODE_STREAM_TOP_MACROS_SVH
`define XML_ENTITY_DECODE_STREAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/xed_pkg.sv
// Types, entity tables and constants shared by the entity decoder modules.
`default_nettype none

package xed_pkg;

	localparam int NUM_FORMS = 6;
	localparam int FORM_MAX  = 6;
	localparam int MAX_HELD  = 5;
	localparam int CNT_W     = 3;

	typedef logic [15:0] unit_t;

	localparam unit_t AMP = 16'h0026;

	// Code units of each entity, padded with zero after its end.
	localparam unit_t FORM_UNITS [NUM_FORMS][FORM_MAX] = '{
		'{16'h0026, 16'h006E, 16'h0062, 16'h0073, 16'h0070, 16'h003B},
		'{16'h0026, 16'h0061, 16'h006D, 16'h0070, 16'h003B, 16'h0000},
		'{16'h0026, 16'h006C, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0026, 16'h0067, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0026, 16'h0071, 16'h0075, 16'h006F, 16'h0074, 16'h003B},
		'{16'h0026, 16'h0061, 16'h0070, 16'h006F, 16'h0073, 16'h003B}
	};

	localparam logic [CNT_W-1:0] FORM_LEN [NUM_FORMS] = '{
		3'd6, 3'd5, 3'd4, 3'd4, 3'd6, 3'd6
	};

	localparam unit_t FORM_VALUE [NUM_FORMS] = '{
		16'h00A0, 16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027
	};

	// One command for the back end: held units to replay, then an optional tail unit.
	typedef struct packed {
		unit_t [MAX_HELD-1:0] units;
		logic [CNT_W-1:0]     count;
		logic                 tail_valid;
		unit_t                tail_unit;
		logic                 tail_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// File: rtl/xed_stream_if.sv
// Stream interfaces for the text input and the decoded output of the entity decoder.
`default_nettype none

interface xed_text_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_text;

	modport source(output valid, output code_unit, output end_of_text, input ready);
	modport sink(input valid, input code_unit, input end_of_text, output ready);
endinterface

interface xed_decoded_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_unit;
	logic        out_last;

	modport source(output valid, output out_unit, output out_last, input ready);
	modport sink(input valid, input out_unit, input out_last, output ready);
endinterface

`default_nettype wire

// File: rtl/xml_entity_decode_stream_top.sv
// Top level of the streaming XML entity decoder for UTF-16 text.
`default_nettype none

// The decoder takes one UTF-16 code unit per transfer on text and replaces the entities
// &nbsp; &amp; &lt; &gt; &quot; &apos; with 0x00A0, '&', '<', '>', '"' and the apostrophe;
// every other unit passes through. While the units after a '&' can still form an entity,
// up to five of them are held inside the front end and nothing comes out. When the match
// breaks, or the text ends, the held units go out in order as literals, followed by the new
// unit (a new '&' in the middle of a text starts a fresh match instead). A completed entity
// yields one unit, and the final result of a text carries out_last. The front end accepts a
// unit in every cycle while the command queue is not full; each unit that produces output
// writes one command into a queue of QUEUE_DEPTH entries, and the back end turns each
// command into one to six results at one result per cycle while decoded.ready stays high.
// The command is written at the edge where its unit transfers; the back end loads its
// results from the queue head into the output register, from which they are offered on
// decoded. text.ready drops only while the command queue is full. That happens when the
// output side is stalled, and also with decoded.ready high when a long replay of held
// units is still draining while new units keep arriving. Because a text never yields more
// results than units, the back end catches up while later units are held, and the
// sustained rate is one unit per cycle whenever decoded.ready stays high.

module xml_entity_decode_stream_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input wire logic      clk,
	input wire logic      arst_n,
	xed_text_if.sink      text,
	xed_decoded_if.source decoded
);
	import xed_pkg::*;

	// Command path from the matcher to the expander.
	logic   push;
	logic   pop;
	cmd_t   push_cmd;
	cmd_t   head;
	qstat_t qstat;

	// The front end classifies each incoming unit against the entity tables.
	xed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	// The queue lets the input keep flowing while a long flush drains on the output.
	xed_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	// The back end replays held units and the tail unit into the output register.
	xed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

`default_nettype wire

// File: rtl/xed_front.sv
// Front end: accepts code units, tracks the entity match and issues output commands.
`default_nettype none

module xed_front (
	input wire logic          clk,
	input wire logic          arst_n,
	xed_text_if.sink          text,
	input wire xed_pkg::qstat_t qstat,
	output logic              push,
	output xed_pkg::cmd_t     cmd
);
	import xed_pkg::*;

	logic [CNT_W-1:0]     count_q;
	logic [NUM_FORMS-1:0] cand_q;
	unit_t                pend_q [MAX_HELD];

	logic [NUM_FORMS-1:0] cand;
	logic [NUM_FORMS-1:0] match;
	logic [NUM_FORMS-1:0] hit_full;
	logic [NUM_FORMS-1:0] hit_pre;
	logic                 full_any;
	logic                 pre_any;
	logic                 take;
	logic                 do_hold;
	logic                 amp_restart;
	unit_t                full_value;

	// With nothing held every entity is still a candidate.
	always_comb begin
		cand = (count_q == '0) ? '1 : cand_q;
		for (int f = 0; f < NUM_FORMS; f++) begin
			match[f]    = cand[f] && (FORM_LEN[f] > count_q) &&
				(text.code_unit == FORM_UNITS[f][count_q]);
			hit_full[f] = match[f] && (FORM_LEN[f] == count_q + CNT_W'(1));
			hit_pre[f]  = match[f] && (FORM_LEN[f] > count_q + CNT_W'(1));
		end
		full_any   = |hit_full;
		pre_any    = |hit_pre;
		full_value = '0;
		for (int f = NUM_FORMS - 1; f >= 0; f--) begin
			if (hit_full[f]) begin
				full_value = FORM_VALUE[f];
			end
		end
	end

	assign text.ready  = !qstat.full;
	assign take        = text.valid && text.ready;
	assign do_hold     = pre_any && !text.end_of_text && (count_q < CNT_W'(MAX_HELD));
	assign amp_restart = (text.code_unit == AMP) && !text.end_of_text;

	always_comb begin
		for (int k = 0; k < MAX_HELD; k++) begin
			cmd.units[k] = pend_q[k];
		end
		cmd.count      = full_any ? '0 : count_q;
		cmd.tail_valid = full_any || !amp_restart;
		cmd.tail_unit  = full_any ? full_value : text.code_unit;
		cmd.tail_last  = text.end_of_text;
	end

	// A held unit or a restarted match produces nothing unless earlier units must be replayed.
	assign push = take && (full_any || (!do_hold && ((count_q != '0) || !amp_restart)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cand_q  <= '0;
		end else if (take) begin
			if (full_any) begin
				count_q <= '0;
			end else if (do_hold) begin
				count_q <= count_q + CNT_W'(1);
				cand_q  <= hit_pre;
			end else if (amp_restart) begin
				count_q <= CNT_W'(1);
				cand_q  <= '1;
			end else begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !full_any) begin
			if (do_hold) begin
				pend_q[count_q] <= text.code_unit;
			end else if (amp_restart) begin
				pend_q[0] <= text.code_unit;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/xed_cmd_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none

module xed_cmd_queue #(
	parameter int DEPTH = 4
) (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            push,
	input wire xed_pkg::cmd_t   push_cmd,
	input wire logic            pop,
	output xed_pkg::cmd_t       head,
	output xed_pkg::qstat_t     stat
);
	import xed_pkg::*;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/xed_back.sv
// Back end: expands each command into the output register, one unit per cycle unless stalled.
`default_nettype none

module xed_back (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire xed_pkg::cmd_t   head,
	input wire xed_pkg::qstat_t qstat,
	output logic                pop,
	xed_decoded_if.source       decoded
);
	import xed_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	unit_t            out_unit_q;
	logic             out_last_q;

	unit_t held_unit;
	unit_t cur_unit;
	logic  cur_last;
	logic  is_final;
	logic  load;

	always_comb begin
		held_unit = '0;
		for (int k = 0; k < MAX_HELD; k++) begin
			if (idx_q == CNT_W'(k)) begin
				held_unit = head.units[k];
			end
		end
		if (idx_q < head.count) begin
			cur_unit = held_unit;
			cur_last = 1'b0;
			is_final = !head.tail_valid && (idx_q + CNT_W'(1) == head.count);
		end else begin
			cur_unit = head.tail_unit;
			cur_last = head.tail_last;
			is_final = 1'b1;
		end
	end

	assign load = !qstat.empty && (!out_valid_q || decoded.ready);
	assign pop  = load && is_final;

	assign decoded.valid    = out_valid_q;
	assign decoded.out_unit = out_unit_q;
	assign decoded.out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_final ? '0 : idx_q + CNT_W'(1);
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_unit_q <= cur_unit;
			out_last_q <= cur_last;
		end
	end

endmodule

`default_nettype wire

// File: rtl/xed_checker.sv
// Port-level checker for the entity decoder and its bind to the top level.
`default_nettype none

`include "xml_entity_decode_stream_top_macros.svh"

module xed_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_unit,
	input wire logic        out_last
);

	logic        in_acc;
	logic        out_acc;
	logic [15:0] bal_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Units taken minus results delivered; it sticks once it reaches the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q <= '0;
		end else if (bal_q != '1) begin
			if (in_acc && !out_acc) begin
				bal_q <= bal_q + 16'd1;
			end else if (out_acc && !in_acc) begin
				bal_q <= bal_q - 16'd1;
			end
		end
	end

	`XED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_unit) && $stable(out_last), "stalled result changed")

	`XED_ASSERT_SAME(a_no_excess, clk, arst_n, out_valid, bal_q != 16'd0,
		"more results than units taken")

	`XED_ASSERT_SAME(a_idle_ready, clk, arst_n, bal_q == 16'd0, in_ready,
		"input stalled with no work outstanding")

endmodule

bind xml_entity_decode_stream_top xed_checker u_xed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text.valid),
	.in_ready  (text.ready),
	.out_valid (decoded.valid),
	.out_ready (decoded.ready),
	.out_unit  (decoded.out_unit),
	.out_last  (decoded.out_last)
);

`default_nettype wire

// File: sim/tb_xml_entity_decode_stream_top.sv
// Self-checking testbench for the streaming XML entity decoder top level.
`timescale 1ns / 1ps

module tb_xml_entity_decode_stream_top;
	import xed_pkg::*;

	// Receiver behaviors for the decoded channel.
	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	// One decoded result as the checker sees it.
	typedef struct packed {
		unit_t unit;
		logic  last;
	} decoded_t;

	localparam int ENT_COUNT = 6;
	localparam int ENT_MAX   = 6;
	localparam int HELD_MAX  = 5;
	localparam int DRAIN_LIMIT = 50000;

	localparam unit_t CH_AMP  = 16'h0026;
	localparam unit_t CH_SEMI = 16'h003B;

	// The entities spelled out as code units, padded with zero after their end.
	// Order: nbsp, amp, lt, gt, quot, apos.
	localparam unit_t ENT_UNITS [ENT_COUNT][ENT_MAX] = '{
		'{16'h0026, 16'h006E, 16'h0062, 16'h0073, 16'h0070, 16'h003B},
		'{16'h0026, 16'h0061, 16'h006D, 16'h0070, 16'h003B, 16'h0000},
		'{16'h0026, 16'h006C, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0026, 16'h0067, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0026, 16'h0071, 16'h0075, 16'h006F, 16'h0074, 16'h003B},
		'{16'h0026, 16'h0061, 16'h0070, 16'h006F, 16'h0073, 16'h003B}
	};
	localparam int ENT_LEN [ENT_COUNT] = '{6, 5, 4, 4, 6, 6};
	localparam unit_t ENT_VALUE [ENT_COUNT] = '{
		16'h00A0, 16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027
	};

	// Every code unit that occurs in some entity, used to build near misses.
	localparam int ALPHA_COUNT = 14;
	localparam unit_t ENT_ALPHA [ALPHA_COUNT] = '{
		16'h0026, 16'h006E, 16'h0062, 16'h0073, 16'h0070, 16'h0061, 16'h006D,
		16'h006C, 16'h0074, 16'h0067, 16'h0071, 16'h0075, 16'h006F, 16'h003B
	};

	logic clk = 1'b0;
	logic arst_n;

	xed_text_if    text_ch();
	xed_decoded_if dec_ch();

	xml_entity_decode_stream_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.decoded(dec_ch)
	);

	// Free-running clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Results still owed by the decoder, oldest first.
	decoded_t expected_units[$];

	// The predictor's own copy of the partial entity held back by the decoder.
	unit_t held_units [HELD_MAX];
	int    held_count = 0;

	int       error_count  = 0;
	rx_mode_t rx_mode      = RX_ALWAYS;
	int       hold_request = 0;

	// Sender burst control: a burst runs for burst_left transfers, and a gap of
	// random length precedes each new burst while sender_idles is set.
	int burst_left   = 0;
	bit sender_idles = 1'b1;
	int max_burst    = 8;
	int max_gap      = 5;

	// Appends one result to the list of owed results.
	function automatic void owe_result(input unit_t unit, input logic last);
		decoded_t r;
		r.unit = unit;
		r.last = last;
		expected_units = {expected_units, r};
	endfunction

	// Predicts what one accepted code unit releases. A completed entity yields
	// its replacement. A unit that extends a live prefix is held, unless the text
	// ends there. Otherwise the held units go out as literals, and the new unit
	// follows, except a '&' in mid-text, which starts a fresh match.
	function automatic void predict_decode(input unit_t unit, input logic eot);
		int full_idx;
		bit prefix;
		bit ok;
		full_idx = -1;
		prefix = 1'b0;
		for (int f = 0; f < ENT_COUNT; f++) begin
			if (ENT_LEN[f] <= held_count)
				continue;
			ok = 1'b1;
			for (int k = 0; k < held_count; k++)
				if (held_units[k] != ENT_UNITS[f][k])
					ok = 1'b0;
			if (unit != ENT_UNITS[f][held_count])
				ok = 1'b0;
			if (!ok)
				continue;
			if (ENT_LEN[f] == held_count + 1)
				full_idx = f;
			else
				prefix = 1'b1;
		end

		if (full_idx >= 0) begin
			owe_result(ENT_VALUE[full_idx], eot);
			held_count = 0;
		end else if (prefix && !eot && held_count < HELD_MAX) begin
			held_units[held_count] = unit;
			held_count++;
		end else begin
			// The held literals never carry the last flag; only the final unit does.
			for (int k = 0; k < held_count; k++)
				owe_result(held_units[k], 1'b0);
			held_count = 0;
			if (unit == CH_AMP && !eot) begin
				held_units[0] = unit;
				held_count = 1;
			end else begin
				owe_result(unit, eot);
			end
		end
	endfunction

	// Offers one code unit and waits for its transfer. Called at a rising edge.
	// Valid stays high from one unit to the next inside a burst; it is lowered
	// only for a gap, so it never gets two assignments in one time step.
	task automatic send_unit(input unit_t unit, input logic eot);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, max_burst);
			gap = sender_idles ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid       <= 1'b1;
		text_ch.code_unit   <= unit;
		text_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!text_ch.ready);
		predict_decode(unit, eot);
	endtask

	// Sends a whole text; the last unit carries the end flag.
	task automatic send_text(input unit_t units[$]);
		foreach (units[i])
			send_unit(units[i], i == units.size() - 1);
	endtask

	// Stops offering and waits until every owed result has arrived.
	task automatic wait_drained();
		int guard;
		guard = 0;
		text_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_units.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (expected_units.size() != 0) begin
			error_count++;
			$display("%0t: results stopped with %0d still owed", $time,
				expected_units.size());
		end
	endtask

	// Builds one text from random pieces. Four pieces in ten are whole or cut entities,
	// so that the decoder keeps reaching its deeper match states; the rest are
	// letters, lone ampersands, near misses and arbitrary 16-bit units.
	task automatic send_random_text(output int sent);
		unit_t units[$];
		int    goal;
		int    f;
		int    cut;
		goal = $urandom_range(1, 12);
		while (units.size() < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					f = $urandom_range(0, ENT_COUNT - 1);
					cut = ($urandom_range(0, 3) == 0) ?
						$urandom_range(1, ENT_LEN[f] - 1) : ENT_LEN[f];
					for (int k = 0; k < cut; k++)
						units = {units, ENT_UNITS[f][k]};
					if (cut < ENT_LEN[f] && $urandom_range(0, 1) == 1)
						units = {units, ENT_ALPHA[$urandom_range(0, ALPHA_COUNT - 1)]};
				end
				4, 5: begin
					units = {units, unit_t'($urandom_range(16'h0061, 16'h007A))};
				end
				6: begin
					units = {units, CH_AMP};
				end
				7, 8: begin
					units = {units, unit_t'($urandom_range(0, 16'hFFFF))};
				end
				default: begin
					units = {units, ENT_ALPHA[$urandom_range(0, ALPHA_COUNT - 1)]};
				end
			endcase
		end
		send_text(units);
		sent = units.size();
	endtask

	// Lowest and highest code units, and a literal 0x00A0: the lowest alone and in mid-text,
	// the highest at both ends of a text, and 0x00A0 as a one-unit text.
	task automatic test_unit_extremes();
		send_unit(16'h0000, 1'b1);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		send_unit(16'h00A0, 1'b1);
		wait_drained();
	endtask

	// Each of the six entities in turn inside one text, ending on the last one.
	task automatic test_each_entity();
		for (int f = 0; f < ENT_COUNT; f++)
			for (int k = 0; k < ENT_LEN[f]; k++)
				send_unit(ENT_UNITS[f][k], f == ENT_COUNT - 1 && k == ENT_LEN[f] - 1);
		wait_drained();
	endtask

	// Prefixes that break: on a plain letter, on a new '&' that restarts the
	// match, and after the longest possible run of five held units.
	task automatic test_broken_prefix();
		unit_t units[$];
		units = '{16'h0026, 16'h0061, 16'h006D, 16'h0078,
			16'h0026, 16'h0071, 16'h0026, 16'h006C, 16'h0074, CH_SEMI,
			16'h0026, 16'h006E, 16'h0062, 16'h0073, 16'h0070, 16'h0058};
		send_text(units);
		wait_drained();
	endtask

	// Texts that end inside a prefix, including a text that is a lone '&' and
	// one that ends with four units held.
	task automatic test_end_in_prefix();
		unit_t units[$];
		units = '{16'h0026, 16'h0071, 16'h0075, 16'h006F};
		send_text(units);
		send_unit(CH_AMP, 1'b1);
		units = '{16'h0026, 16'h006E, 16'h0062, 16'h0073, 16'h0070};
		send_text(units);
		wait_drained();
	endtask

	// Random texts under one receiver behavior until about item_goal units went in.
	task automatic test_random_texts(input rx_mode_t mode, input int item_goal);
		int total;
		int n;
		rx_mode = mode;
		total = 0;
		while (total < item_goal) begin
			// Some texts go out back to back with no sender gaps at all.
			sender_idles = ($urandom_range(0, 3) != 0);
			send_random_text(n);
			total += n;
		end
		sender_idles = 1'b1;
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering,
	// so the command queue fills and the decoder stalls its input.
	task automatic test_output_hold_off();
		int total;
		int n;
		rx_mode = RX_ALWAYS;
		sender_idles = 1'b0;
		hold_request = 80;
		total = 0;
		while (total < 40) begin
			send_random_text(n);
			total += n;
		end
		sender_idles = 1'b1;
		wait_drained();
	endtask

	// Receiver: a behavior picked by the test, overridden by a hold-off whose
	// length this process counts down itself.
	initial begin : receiver
		int hold_left;
		int rx_phase;
		hold_left = 0;
		rx_phase = 0;
		dec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_phase++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				dec_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_ALWAYS:   dec_ch.ready <= 1'b1;
					RX_RANDOM:   dec_ch.ready <= ($urandom_range(0, 9) < 7);
					RX_PERIODIC: dec_ch.ready <= ((rx_phase % 7) < 4);
					default:     dec_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Checker: every transfer on the decoded channel is matched against the
	// oldest owed result, field by field.
	always @(posedge clk) begin : check_results
		decoded_t want;
		if (arst_n && dec_ch.valid && dec_ch.ready) begin
			if (expected_units.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing owed: expected none, actual unit %h last %b",
					$time, dec_ch.out_unit, dec_ch.out_last);
			end else begin
				want = expected_units.pop_front();
				if (dec_ch.out_unit !== want.unit) begin
					error_count++;
					$display("%0t: out_unit mismatch: expected %h actual %h",
						$time, want.unit, dec_ch.out_unit);
				end
				if (dec_ch.out_last !== want.last) begin
					error_count++;
					$display("%0t: out_last mismatch: expected %b actual %b",
						$time, want.last, dec_ch.out_last);
				end
			end
		end
	end

	// Main sequence: reset once, the directed tests, then random texts under
	// each receiver behavior and the hold-off. Every test ends by waiting
	// until all owed results have arrived.
	initial begin
		arst_n              <= 1'b0;
		text_ch.valid       <= 1'b0;
		text_ch.code_unit   <= '0;
		text_ch.end_of_text <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unit_extremes();
		test_each_entity();
		test_broken_prefix();
		test_end_in_prefix();

		test_random_texts(RX_ALWAYS, 80);
		test_random_texts(RX_RANDOM, 80);
		test_output_hold_off();
		test_random_texts(RX_PERIODIC, 80);
		test_random_texts(RX_SPARSE, 70);

		// Keep the receiver ready for stray output, then check that nothing is still owed.
		rx_mode = RX_ALWAYS;
		repeat (10) @(posedge clk);
		if (expected_units.size() != 0) begin
			error_count++;
			$display("%0t: %0d results never arrived", $time, expected_units.size());
		end

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: the slowest correct run ends long before this.
	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

endmodule
